[rtl/core/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked property checks, with an active-low reset disable or without one.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_CLK_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define ASSERT_CLK_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

[rtl/core/cwsb_pkg.sv]
// ----------------------------------------------------------------------------
// cwsb_pkg
// Shared constants and codes of the column window sum buffer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package cwsb_pkg;
  localparam int MAX_ROWS_DEF = 256;
  localparam int MAX_COLS_DEF = 8;

  localparam int SUM_W  = 40;
  localparam int OUT_W  = 43;
  localparam int VAL_W  = 32;
  localparam int CFG_W  = 9;

  localparam logic [2:0] CMD_PUSH     = 3'd0;
  localparam logic [2:0] CMD_POP      = 3'd1;
  localparam logic [2:0] CMD_READ     = 3'd2;
  localparam logic [2:0] CMD_CLEAR    = 3'd3;
  localparam logic [2:0] CMD_COLSUM   = 3'd4;
  localparam logic [2:0] CMD_COLMEAN  = 3'd5;
  localparam logic [2:0] CMD_TOTSUM   = 3'd6;
  localparam logic [2:0] CMD_TOTMEAN  = 3'd7;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_REJECT  = 2'd1;
  localparam logic [1:0] ST_NO_ROWS = 2'd2;

  localparam logic CFG_ROWS_IN_USE = 1'b0;
  localparam logic CFG_COLS_IN_USE = 1'b1;

  localparam logic [8:0] ROWS_IN_USE_RST = 9'd256;
  localparam logic [3:0] COLS_IN_USE_RST = 4'd8;
endpackage
`default_nettype wire

[rtl/core/cwsb_chan_if.sv]
// ----------------------------------------------------------------------------
// cwsb channel interfaces
// Valid/ready command and result channels of the column window sum buffer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
interface cwsb_cmd_if;
  logic               valid;
  logic               ready;
  logic [2:0]         command;
  logic signed [31:0] value;
  logic               row_end;
  logic [8:0]         count;
  logic [7:0]         row;
  logic [2:0]         column;

  modport source (output valid, command, value, row_end, count, row, column, input ready);
  modport sink   (input valid, command, value, row_end, count, row, column, output ready);
endinterface

interface cwsb_res_if;
  logic               valid;
  logic               ready;
  logic signed [42:0] result_value;
  logic [1:0]         status;
  logic [8:0]         row_count;

  modport source (output valid, result_value, status, row_count, input ready);
  modport sink   (input valid, result_value, status, row_count, output ready);
endinterface
`default_nettype wire

[rtl/core/column_window_sum_buffer.sv]
// Push writes one sample, then on row end zero-fills each unwritten column. Read waits
// on the registered store read. Pop does one store read and one sum update per column,
// over all MAX_COLS columns of each popped row. Column sum is direct; total sum adds up
// cols_in_use columns. Column mean runs a shared restoring divider; total mean sums first.
// One command at a time; ready only while idle with no result waiting. Synchronous
// active-low reset clears control state and sums; the sample store needs no clearing pass.
// ----------------------------------------------------------------------------
// column_window_sum_buffer
// Multi-column sample window with ring storage, running column sums and means.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module column_window_sum_buffer #(
  parameter int MAX_ROWS = cwsb_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS = cwsb_pkg::MAX_COLS_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_wr_en,
  input  wire logic       cfg_index,
  input  wire logic [8:0] cfg_wdata,
  cwsb_cmd_if.sink        in_bus,
  cwsb_res_if.source      out_bus
);
  localparam int HW  = $clog2(MAX_ROWS + 1);
  localparam int SLW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CW  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int CNW = $clog2(MAX_COLS + 1);
  localparam int AW  = SLW + CW;
  localparam int TW  = cwsb_pkg::SUM_W + CW;
  localparam int DVW = HW + CNW;
  localparam int DCW = $clog2(TW + 1);
  localparam int SW  = cwsb_pkg::SUM_W;
  localparam int OW  = cwsb_pkg::OUT_W;
  localparam int VAL_PAD = cwsb_pkg::VAL_W;

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_FILL    = 4'd1;
  localparam logic [3:0] S_POP_RD  = 4'd2;
  localparam logic [3:0] S_POP_SUB = 4'd3;
  localparam logic [3:0] S_RD_WAIT = 4'd4;
  localparam logic [3:0] S_RD_DATA = 4'd5;
  localparam logic [3:0] S_TOT     = 4'd6;
  localparam logic [3:0] S_MUL     = 4'd7;
  localparam logic [3:0] S_DIV     = 4'd8;
  localparam logic [3:0] S_SIGN    = 4'd9;

  logic [3:0]           state_r;
  logic [8:0]           rows_in_use_r;
  logic [3:0]           cols_in_use_r;
  logic signed [SW-1:0] sums_r [MAX_COLS];
  logic [SLW-1:0]       oldest_r;
  logic [HW-1:0]        rows_held_r;
  logic [CNW-1:0]       npc_r;
  logic [SLW-1:0]       slot_r;
  logic [CW-1:0]        col_r;
  logic [HW-1:0]        k_r;
  logic [HW-1:0]        cnt_r;
  logic                 tmean_r;
  logic signed [TW-1:0] acc_r;
  logic [TW-1:0]        dvd_r;
  logic [DVW-1:0]       dvs_r;
  logic [DVW-1:0]       rem_r;
  logic [DCW-1:0]       dcnt_r;
  logic                 neg_r;
  logic                 out_valid_r;
  logic signed [OW-1:0] out_value_r;
  logic [1:0]           out_status_r;

  logic [HW-1:0]        cap_rows;
  logic [CNW-1:0]       ncols;
  logic                 accept;
  logic [SLW-1:0]       push_slot;
  logic [SLW-1:0]       read_slot;
  logic [SLW-1:0]       next_slot;
  logic                 push_rej;
  logic                 pop_rej;
  logic [CW-1:0]        sum_idx;
  logic signed [SW-1:0] sum_sel;
  logic signed [SW-1:0] val_ext;
  logic signed [SW-1:0] rd_ext;
  logic signed [SW-1:0] sum_res;
  logic signed [TW-1:0] sum_tw;
  logic signed [TW-1:0] acc_add;
  logic signed [OW+SW-1:0] sum_wide;
  logic signed [OW+TW-1:0] acc_wide;
  logic signed [OW+TW-1:0] q_wide;
  logic signed [OW+VAL_PAD-1:0] rd_wide;
  logic [DVW:0]         rem_sh;
  logic                 rem_ge;
  logic [DVW:0]         rem_dif;
  logic [AW-1:0]        ram_waddr;
  logic [AW-1:0]        ram_raddr;
  logic                 ram_we;
  logic [31:0]          ram_wdata;
  logic [31:0]          ram_rdata;

  function automatic logic [SLW-1:0] wrap_slot(input logic [31:0] a);
    logic [31:0] t;
    t = (a >= 32'(MAX_ROWS)) ? a - 32'(MAX_ROWS) : a;
    return t[SLW-1:0];
  endfunction

  always_comb begin
    if (rows_in_use_r == 9'd0) begin
      cap_rows = HW'(1);
    end else if (32'(rows_in_use_r) > 32'(MAX_ROWS)) begin
      cap_rows = HW'(MAX_ROWS);
    end else begin
      cap_rows = HW'(rows_in_use_r);
    end
    if (cols_in_use_r == 4'd0) begin
      ncols = CNW'(1);
    end else if (32'(cols_in_use_r) > 32'(MAX_COLS)) begin
      ncols = CNW'(MAX_COLS);
    end else begin
      ncols = CNW'(cols_in_use_r);
    end
  end

  assign in_bus.ready = (state_r == S_IDLE) && !out_valid_r;
  assign accept       = in_bus.valid && in_bus.ready;
  assign push_slot    = wrap_slot(32'(oldest_r) + 32'(rows_held_r));
  assign read_slot    = wrap_slot(32'(oldest_r) + 32'(in_bus.row));
  assign next_slot    = wrap_slot(32'(slot_r) + 32'd1);
  assign push_rej     = (rows_held_r >= cap_rows) || (npc_r >= ncols);
  assign pop_rej      = (in_bus.count == 9'd0) || (32'(in_bus.count) > 32'(rows_held_r));

  assign sum_idx  = (state_r == S_IDLE) ?
                    ((in_bus.command == cwsb_pkg::CMD_PUSH) ? CW'(npc_r) : CW'(in_bus.column)) :
                    col_r;
  assign sum_sel  = sums_r[sum_idx];
  assign val_ext  = SW'(in_bus.value);
  assign rd_ext   = SW'(signed'(ram_rdata));
  assign sum_res  = (state_r == S_POP_SUB) ? sum_sel - rd_ext : sum_sel + val_ext;
  assign sum_tw   = TW'(sum_sel);
  assign acc_add  = acc_r + sum_tw;
  assign sum_wide = (OW+SW)'(sum_sel);
  assign acc_wide = (OW+TW)'(acc_add);
  assign q_wide   = (OW+TW)'(neg_r ? -signed'(dvd_r) : signed'(dvd_r));
  assign rd_wide  = (OW+VAL_PAD)'(rd_ext);

  assign rem_sh  = {rem_r, dvd_r[TW-1]};
  assign rem_dif = rem_sh - {1'b0, dvs_r};
  assign rem_ge  = rem_sh >= {1'b0, dvs_r};

  assign ram_we    = (state_r == S_FILL) ||
                     (accept && (in_bus.command == cwsb_pkg::CMD_PUSH) && !push_rej);
  assign ram_waddr = (state_r == S_IDLE) ? {push_slot, CW'(npc_r)} : {slot_r, col_r};
  assign ram_wdata = (state_r == S_IDLE) ? in_bus.value : 32'd0;
  assign ram_raddr = {slot_r, col_r};

  cwsb_ram #(
    .WIDTH (cwsb_pkg::VAL_W),
    .DEPTH (MAX_ROWS * (2 ** CW))
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_in_use_r <= cwsb_pkg::ROWS_IN_USE_RST;
      cols_in_use_r <= cwsb_pkg::COLS_IN_USE_RST;
    end else if (cfg_wr_en) begin
      if (cfg_index == cwsb_pkg::CFG_ROWS_IN_USE) begin
        rows_in_use_r <= cfg_wdata;
      end else begin
        cols_in_use_r <= cfg_wdata[3:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      oldest_r    <= '0;
      rows_held_r <= '0;
      npc_r       <= '0;
      out_valid_r <= 1'b0;
      for (int c = 0; c < MAX_COLS; c++) begin
        sums_r[c] <= '0;
      end
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            case (in_bus.command)
              cwsb_pkg::CMD_PUSH: begin
                out_value_r  <= '0;
                out_status_r <= push_rej ? cwsb_pkg::ST_REJECT : cwsb_pkg::ST_OK;
                if (push_rej) begin
                  out_valid_r  <= 1'b1;
                end else begin
                  sums_r[sum_idx] <= sum_res;
                  if (in_bus.row_end) begin
                    rows_held_r <= rows_held_r + HW'(1);
                    npc_r       <= '0;
                    if (32'(npc_r) + 32'd1 < 32'(MAX_COLS)) begin
                      slot_r  <= push_slot;
                      col_r   <= CW'(npc_r + CNW'(1));
                      state_r <= S_FILL;
                    end else begin
                      out_valid_r <= 1'b1;
                    end
                  end else begin
                    npc_r       <= npc_r + CNW'(1);
                    out_valid_r <= 1'b1;
                  end
                end
              end
              cwsb_pkg::CMD_POP: begin
                out_value_r  <= '0;
                out_status_r <= pop_rej ? cwsb_pkg::ST_REJECT : cwsb_pkg::ST_OK;
                if (pop_rej) begin
                  out_valid_r  <= 1'b1;
                end else begin
                  slot_r  <= oldest_r;
                  col_r   <= '0;
                  k_r     <= '0;
                  cnt_r   <= HW'(in_bus.count);
                  state_r <= S_POP_RD;
                end
              end
              cwsb_pkg::CMD_READ: begin
                out_value_r  <= '0;
                out_status_r <= cwsb_pkg::ST_OK;
                if ((32'(in_bus.row) < 32'(rows_held_r)) &&
                    (32'(in_bus.column) < 32'(ncols))) begin
                  slot_r  <= read_slot;
                  col_r   <= CW'(in_bus.column);
                  state_r <= S_RD_WAIT;
                end else begin
                  out_valid_r <= 1'b1;
                end
              end
              cwsb_pkg::CMD_CLEAR: begin
                out_value_r  <= '0;
                out_status_r <= cwsb_pkg::ST_OK;
                for (int c = 0; c < MAX_COLS; c++) begin
                  sums_r[c] <= '0;
                end
                oldest_r    <= '0;
                rows_held_r <= '0;
                npc_r       <= '0;
                out_valid_r <= 1'b1;
              end
              cwsb_pkg::CMD_COLSUM: begin
                out_status_r <= cwsb_pkg::ST_OK;
                out_value_r  <= (32'(in_bus.column) < 32'(ncols)) ? sum_wide[OW-1:0] : '0;
                out_valid_r  <= 1'b1;
              end
              cwsb_pkg::CMD_COLMEAN: begin
                out_value_r  <= '0;
                out_status_r <= (rows_held_r == '0) ? cwsb_pkg::ST_NO_ROWS : cwsb_pkg::ST_OK;
                if (rows_held_r == '0) begin
                  out_valid_r  <= 1'b1;
                end else if (32'(in_bus.column) < 32'(ncols)) begin
                  neg_r   <= sum_tw[TW-1];
                  dvd_r   <= sum_tw[TW-1] ? TW'(-sum_tw) : TW'(sum_tw);
                  dvs_r   <= DVW'(rows_held_r);
                  rem_r   <= '0;
                  dcnt_r  <= '0;
                  state_r <= S_DIV;
                end else begin
                  out_valid_r <= 1'b1;
                end
              end
              default: begin
                out_value_r <= '0;
                if ((in_bus.command == cwsb_pkg::CMD_TOTMEAN) && (rows_held_r == '0)) begin
                  out_status_r <= cwsb_pkg::ST_NO_ROWS;
                  out_valid_r  <= 1'b1;
                end else begin
                  out_status_r <= cwsb_pkg::ST_OK;
                  tmean_r <= (in_bus.command == cwsb_pkg::CMD_TOTMEAN);
                  acc_r   <= '0;
                  col_r   <= '0;
                  state_r <= S_TOT;
                end
              end
            endcase
          end
        end
        S_FILL: begin
          if (32'(col_r) == 32'(MAX_COLS - 1)) begin
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end else begin
            col_r <= col_r + CW'(1);
          end
        end
        S_POP_RD: begin
          state_r <= S_POP_SUB;
        end
        S_POP_SUB: begin
          sums_r[col_r] <= sum_res;
          if (32'(col_r) == 32'(MAX_COLS - 1)) begin
            col_r  <= '0;
            slot_r <= next_slot;
            k_r    <= k_r + HW'(1);
            if ((k_r + HW'(1)) == cnt_r) begin
              oldest_r    <= next_slot;
              rows_held_r <= rows_held_r - cnt_r;
              out_valid_r <= 1'b1;
              state_r     <= S_IDLE;
            end else begin
              state_r <= S_POP_RD;
            end
          end else begin
            col_r   <= col_r + CW'(1);
            state_r <= S_POP_RD;
          end
        end
        S_RD_WAIT: begin
          state_r <= S_RD_DATA;
        end
        S_RD_DATA: begin
          out_value_r <= rd_wide[OW-1:0];
          out_valid_r <= 1'b1;
          state_r     <= S_IDLE;
        end
        S_TOT: begin
          acc_r <= acc_add;
          if ((CNW'(col_r) + CNW'(1)) == ncols) begin
            if (tmean_r) begin
              state_r <= S_MUL;
            end else begin
              out_value_r <= acc_wide[OW-1:0];
              out_valid_r <= 1'b1;
              state_r     <= S_IDLE;
            end
          end else begin
            col_r <= col_r + CW'(1);
          end
        end
        S_MUL: begin
          neg_r   <= acc_r[TW-1];
          dvd_r   <= acc_r[TW-1] ? TW'(-acc_r) : TW'(acc_r);
          dvs_r   <= DVW'(rows_held_r) * DVW'(ncols);
          rem_r   <= '0;
          dcnt_r  <= '0;
          state_r <= S_DIV;
        end
        S_DIV: begin
          rem_r  <= rem_ge ? rem_dif[DVW-1:0] : rem_sh[DVW-1:0];
          dvd_r  <= {dvd_r[TW-2:0], rem_ge};
          dcnt_r <= dcnt_r + DCW'(1);
          if (32'(dcnt_r) == 32'(TW - 1)) begin
            state_r <= S_SIGN;
          end
        end
        S_SIGN: begin
          out_value_r <= q_wide[OW-1:0];
          out_valid_r <= 1'b1;
          state_r     <= S_IDLE;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_bus.valid        = out_valid_r;
  assign out_bus.result_value = out_value_r;
  assign out_bus.status       = out_status_r;
  assign out_bus.row_count    = 9'(rows_held_r);

  `ASSERT_CLK(a_ready_no_pending, clk, rst_n, in_bus.ready |-> !out_bus.valid, "ready, result held")
  `ASSERT_CLK(a_accept_busy, clk, rst_n, accept |=> !in_bus.ready, "ready after accept")
  `ASSERT_CLK(a_rows_bound, clk, rst_n, 32'(rows_held_r) <= 32'(MAX_ROWS), "rows over capacity")
  `ASSERT_CLK(a_out_drop, clk, rst_n, (out_bus.valid && out_bus.ready) |=> !out_bus.valid, "repeat")
endmodule
`default_nettype wire

[rtl/core/cwsb_ram.sv]
// ----------------------------------------------------------------------------
// cwsb_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module cwsb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2048
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;
endmodule
`default_nettype wire

[dv/column_window_sum_buffer_test.sv]
// ----------------------------------------------------------------------------
// column_window_sum_buffer_test
// Drives push, pop, read, clear, sum and mean commands into the column window
// buffer under random idling on both channels, predicts every result beat
// from a behavioral window model and compares each field in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module column_window_sum_buffer_test;
  localparam int NROWS = cwsb_pkg::MAX_ROWS_DEF;
  localparam int NCOLS = cwsb_pkg::MAX_COLS_DEF;

  typedef struct packed {
    logic signed [42:0] value;
    logic [1:0]         status;
    logic [8:0]         rows;
  } window_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_wr_en = 1'b0;
  logic cfg_index = 1'b0;
  logic [8:0] cfg_wdata = '0;

  cwsb_cmd_if cmd_bus ();
  cwsb_res_if res_bus ();

  column_window_sum_buffer uut (
    .clk(clk), .rst_n(rst_n), .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata), .in_bus(cmd_bus.sink), .out_bus(res_bus.source)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // window model state
  logic signed [31:0] win_data [NROWS][NCOLS];
  logic signed [39:0] col_total [NCOLS];
  int unsigned oldest_slot, held_rows, fill_col, row_cap_reg, col_cap_reg;

  window_result_t pending_results [$];
  int error_count = 0;
  bit idle_enable = 1'b1;
  int hold_cycles = 0;

  function automatic int unsigned row_cap();
    if (row_cap_reg < 1) return 1;
    if (row_cap_reg > NROWS) return NROWS;
    return row_cap_reg;
  endfunction

  function automatic int unsigned col_cap();
    if (col_cap_reg < 1) return 1;
    if (col_cap_reg > NCOLS) return NCOLS;
    return col_cap_reg;
  endfunction

  function automatic logic signed [42:0] sum_of_columns();
    logic signed [42:0] acc;
    acc = '0;
    for (int c = 0; c < col_cap(); c++) acc += 43'(col_total[c]);
    return acc;
  endfunction

  function automatic void window_clear();
    foreach (col_total[c]) col_total[c] = '0;
    oldest_slot = 0;
    held_rows = 0;
    fill_col = 0;
  endfunction

  function automatic window_result_t window_step(logic [2:0] op, logic signed [31:0] val,
                                                 logic last, logic [8:0] cnt,
                                                 logic [7:0] rsel, logic [2:0] csel);
    window_result_t r;
    int unsigned s;
    logic signed [63:0] num, den;
    r = '0;
    case (op)
      cwsb_pkg::CMD_PUSH: begin
        if (held_rows >= row_cap() || fill_col >= col_cap()) begin
          r.status = cwsb_pkg::ST_REJECT;
        end else begin
          s = (oldest_slot + held_rows) % NROWS;
          win_data[s][fill_col] = val;
          col_total[fill_col] = col_total[fill_col] + 40'(val);
          fill_col++;
          if (last) begin
            for (int c = fill_col; c < NCOLS; c++) win_data[s][c] = '0;
            held_rows++;
            fill_col = 0;
          end
        end
      end
      cwsb_pkg::CMD_POP: begin
        if (cnt == 0 || cnt > held_rows) begin
          r.status = cwsb_pkg::ST_REJECT;
        end else begin
          for (int k = 0; k < cnt; k++) begin
            s = (oldest_slot + k) % NROWS;
            for (int c = 0; c < NCOLS; c++)
              col_total[c] = col_total[c] - 40'(win_data[s][c]);
          end
          oldest_slot = (oldest_slot + cnt) % NROWS;
          held_rows -= cnt;
        end
      end
      cwsb_pkg::CMD_READ: begin
        if (rsel < held_rows && csel < col_cap())
          r.value = 43'(win_data[(oldest_slot + rsel) % NROWS][csel]);
      end
      cwsb_pkg::CMD_CLEAR: window_clear();
      cwsb_pkg::CMD_COLSUM: begin
        if (csel < col_cap()) r.value = 43'(col_total[csel]);
      end
      cwsb_pkg::CMD_COLMEAN: begin
        if (held_rows == 0) r.status = cwsb_pkg::ST_NO_ROWS;
        else if (csel < col_cap()) begin
          num = 64'(col_total[csel]);
          den = held_rows;
          r.value = 43'(num / den);
        end
      end
      cwsb_pkg::CMD_TOTSUM: r.value = sum_of_columns();
      default: begin
        if (held_rows == 0) r.status = cwsb_pkg::ST_NO_ROWS;
        else begin
          num = 64'(sum_of_columns());
          den = held_rows * col_cap();
          r.value = 43'(num / den);
        end
      end
    endcase
    r.rows = 9'(held_rows);
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  task automatic send_beat(logic [2:0] op, logic signed [31:0] val, logic last,
                           logic [8:0] cnt, logic [7:0] rsel, logic [2:0] csel);
    int gap;
    if (idle_enable && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 13);
      cmd_bus.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    cmd_bus.valid <= 1'b1;
    cmd_bus.command <= op;
    cmd_bus.value <= val;
    cmd_bus.row_end <= last;
    cmd_bus.count <= cnt;
    cmd_bus.row <= rsel;
    cmd_bus.column <= csel;
    do @(posedge clk); while (!cmd_bus.ready);
    pending_results.push_back(window_step(op, val, last, cnt, rsel, csel));
    @(negedge clk);
  endtask

  task automatic write_register(logic idx, logic [8:0] data);
    cmd_bus.valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    if (idx == cwsb_pkg::CFG_ROWS_IN_USE) row_cap_reg = data;
    else col_cap_reg = data[3:0];
  endtask

  // result checker
  always @(posedge clk) begin
    window_result_t want;
    if (rst_n && res_bus.valid && res_bus.ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected beat", 0, 0);
      end else begin
        want = pending_results.pop_front();
        if (res_bus.result_value !== want.value)
          report_mismatch("result_value", res_bus.result_value, want.value);
        if (res_bus.status !== want.status)
          report_mismatch("status", res_bus.status, want.status);
        if (res_bus.row_count !== want.rows)
          report_mismatch("row_count", res_bus.row_count, want.rows);
      end
    end
  end

  // receiver stalls
  initial begin
    int gap;
    res_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        res_bus.ready <= 1'b0;
        repeat (hold_cycles) @(negedge clk);
        hold_cycles = 0;
      end else if (idle_enable && $urandom_range(0, 5) == 0) begin
        gap = $urandom_range(1, 13);
        res_bus.ready <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end else begin
        res_bus.ready <= 1'b1;
      end
    end
  end

  task automatic push_row(int unsigned n, bit random_vals);
    for (int c = 0; c < n; c++)
      send_beat(cwsb_pkg::CMD_PUSH, random_vals ? 32'($urandom) : 32'(c + 1), c == n - 1,
                0, 0, 0);
  endtask

  task automatic query_all();
    for (logic [3:0] op = cwsb_pkg::CMD_READ; op <= cwsb_pkg::CMD_TOTMEAN; op++)
      if (op != cwsb_pkg::CMD_CLEAR)
        send_beat(op[2:0], 0, 0, 0, 0, 3'($urandom));
  endtask

  task automatic test_directed();
    send_beat(cwsb_pkg::CMD_COLMEAN, 0, 0, 0, 0, 0);
    send_beat(cwsb_pkg::CMD_TOTMEAN, 0, 0, 0, 0, 0);
    send_beat(cwsb_pkg::CMD_POP, 0, 0, 0, 0, 0);
    send_beat(cwsb_pkg::CMD_PUSH, 32'sh7fffffff, 0, 0, 0, 0);
    send_beat(cwsb_pkg::CMD_PUSH, 32'sh80000000, 0, 0, 0, 1);
    send_beat(cwsb_pkg::CMD_PUSH, 32'hffffffff, 1, 0, 0, 2);
    push_row(8, 0);
    send_beat(cwsb_pkg::CMD_PUSH, 32'h5, 0, 0, 0, 0);
    send_beat(cwsb_pkg::CMD_READ, 0, 0, 0, 0, 0);
    send_beat(cwsb_pkg::CMD_READ, 0, 0, 0, 1, 7);
    send_beat(cwsb_pkg::CMD_READ, 0, 0, 0, 255, 2);
    send_beat(cwsb_pkg::CMD_COLSUM, 0, 0, 0, 0, 1);
    send_beat(cwsb_pkg::CMD_COLMEAN, 0, 0, 0, 0, 7);
    send_beat(cwsb_pkg::CMD_TOTSUM, 0, 0, 0, 0, 0);
    send_beat(cwsb_pkg::CMD_TOTMEAN, 0, 0, 0, 0, 0);
    send_beat(cwsb_pkg::CMD_POP, 0, 0, 9'd256, 0, 0);
    send_beat(cwsb_pkg::CMD_POP, 0, 0, 9'd1, 0, 0);
    send_beat(cwsb_pkg::CMD_PUSH, 32'h6, 1, 0, 0, 0);
    send_beat(cwsb_pkg::CMD_READ, 0, 0, 0, 1, 0);
    send_beat(cwsb_pkg::CMD_CLEAR, 0, 0, 0, 0, 0);
    send_beat(cwsb_pkg::CMD_TOTMEAN, 0, 0, 0, 0, 0);
  endtask

  // small window and narrow rows: full-window and past-last-column rejects
  task automatic test_small_window();
    write_register(cwsb_pkg::CFG_ROWS_IN_USE, 9'd2);
    write_register(cwsb_pkg::CFG_COLS_IN_USE, 4'd3);
    push_row(3, 1);
    send_beat(cwsb_pkg::CMD_PUSH, 32'h1, 0, 0, 0, 0);
    send_beat(cwsb_pkg::CMD_PUSH, 32'h2, 0, 0, 0, 0);
    send_beat(cwsb_pkg::CMD_PUSH, 32'h3, 0, 0, 0, 0);
    send_beat(cwsb_pkg::CMD_PUSH, 32'h4, 1, 0, 0, 0);
    push_row(2, 1);
    push_row(1, 1);
    query_all();
    send_beat(cwsb_pkg::CMD_POP, 0, 0, 9'd2, 0, 0);
    write_register(cwsb_pkg::CFG_ROWS_IN_USE, 9'd1);
    write_register(cwsb_pkg::CFG_COLS_IN_USE, 4'd1);
    push_row(1, 1);
    push_row(1, 1);
    query_all();
    write_register(cwsb_pkg::CFG_ROWS_IN_USE, 9'd0);
    write_register(cwsb_pkg::CFG_COLS_IN_USE, 4'd0);
    push_row(1, 1);
    query_all();
    write_register(cwsb_pkg::CFG_ROWS_IN_USE, 9'd511);
    write_register(cwsb_pkg::CFG_COLS_IN_USE, 4'd15);
    send_beat(cwsb_pkg::CMD_CLEAR, 0, 0, 0, 0, 0);
  endtask

  // hold off results while further commands wait behind the pending one
  task automatic test_backpressure();
    hold_cycles = 400;
    for (int i = 0; i < 30; i++) push_row($urandom_range(1, 8), 1);
    send_beat(cwsb_pkg::CMD_POP, 0, 0, 9'd30, 0, 0);
  endtask

  task automatic random_phase(int unsigned items);
    int unsigned sent, n, pick;
    sent = 0;
    while (sent < items) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        n = $urandom_range(1, col_cap() + 1);
        push_row(n, 1);
        sent += n;
      end else if (pick < 52) begin
        send_beat(cwsb_pkg::CMD_PUSH, 32'($urandom), 1'($urandom), 9'($urandom),
                  8'($urandom), 3'($urandom));
        sent++;
      end else if (pick < 60) begin
        n = held_rows > 0 && $urandom_range(0, 4) != 0 ? $urandom_range(1, held_rows)
                                                       : $urandom_range(0, 511);
        send_beat(cwsb_pkg::CMD_POP, 0, 0, 9'(n), 0, 0);
        sent++;
      end else if (pick < 75) begin
        n = held_rows > 0 && $urandom_range(0, 3) != 0 ? $urandom_range(0, held_rows - 1)
                                                       : $urandom_range(0, 255);
        send_beat(cwsb_pkg::CMD_READ, 32'($urandom), 0, 0, 8'(n), 3'($urandom));
        sent++;
      end else if (pick < 77) begin
        send_beat(cwsb_pkg::CMD_CLEAR, 0, 0, 0, 0, 0);
        sent++;
      end else begin
        send_beat(3'($urandom_range(4, 7)), 0, 0, 0, 0, 3'($urandom));
        sent++;
      end
    end
  endtask

  task automatic test_random();
    write_register(cwsb_pkg::CFG_ROWS_IN_USE, 9'd4);
    write_register(cwsb_pkg::CFG_COLS_IN_USE, 4'd5);
    random_phase(300);
    write_register(cwsb_pkg::CFG_ROWS_IN_USE, 9'd256);
    write_register(cwsb_pkg::CFG_COLS_IN_USE, 4'd8);
    send_beat(cwsb_pkg::CMD_CLEAR, 0, 0, 0, 0, 0);
    random_phase(400);
    write_register(cwsb_pkg::CFG_ROWS_IN_USE, 9'd17);
    write_register(cwsb_pkg::CFG_COLS_IN_USE, 4'd2);
    random_phase(250);
    idle_enable = 1'b0;
    write_register(cwsb_pkg::CFG_ROWS_IN_USE, 9'd40);
    write_register(cwsb_pkg::CFG_COLS_IN_USE, 4'd8);
    random_phase(350);
  endtask

  initial begin
    cmd_bus.valid = 1'b0;
    cmd_bus.command = cwsb_pkg::CMD_PUSH;
    cmd_bus.value = '0;
    cmd_bus.row_end = 1'b0;
    cmd_bus.count = '0;
    cmd_bus.row = '0;
    cmd_bus.column = '0;
    row_cap_reg = cwsb_pkg::ROWS_IN_USE_RST;
    col_cap_reg = cwsb_pkg::COLS_IN_USE_RST;
    window_clear();
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed();
    test_small_window();
    test_backpressure();
    test_random();
    cmd_bus.valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (100) @(negedge clk);
    if (error_count == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

  initial begin
    #400ms;
    $display("simulation failed");
    $finish;
  end
endmodule

[sim.f]
+incdir+rtl/core
rtl/core/cwsb_pkg.sv
rtl/core/cwsb_chan_if.sv
rtl/core/cwsb_ram.sv
rtl/core/column_window_sum_buffer.sv
dv/column_window_sum_buffer_test.sv
